// File: src/wfc_pkg.sv
// Package: shared types and constants for the WUDS face coefficient core.
`timescale 1ns / 1ps
package wfc_pkg;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam int WGT_BITS = 16;

    // One classified face as it travels from front to back.
    typedef struct packed {
        logic [30:0] rho;
        logic [31:0] vmag;
        logic [30:0] mi;
        logic        neg;
        logic        zero_mi;
    } face_t;
endpackage

// File: src/wfc_front.sv
// Front end: accept faces, split velocity sign and magnitude, flag zero viscosity.
`timescale 1ns / 1ps
module wfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [30:0]     face_density,
    input  logic [31:0]     face_velocity,
    input  logic [30:0]     face_viscosity,
    output logic            q_valid,
    input  logic            q_stall,
    output wfc_pkg::face_t  q_face
);
    logic           full_reg;
    wfc_pkg::face_t face_reg;
    logic           take;

    assign in_stall = full_reg && q_stall;
    assign take     = in_valid && !in_stall;
    assign q_valid  = full_reg;
    assign q_face   = face_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            face_reg.rho     <= face_density;
            face_reg.neg     <= face_velocity[31];
            face_reg.vmag    <= face_velocity[31] ? (32'd0 - face_velocity) : face_velocity;
            face_reg.mi      <= face_viscosity;
            face_reg.zero_mi <= (face_viscosity == 31'd0);
        end
    end
endmodule

// File: src/wfc_back.sv
// Back end: Peclet quotient, squaring and the two weight quotients, one face a cycle while the output is not stalled.
`timescale 1ns / 1ps
module wfc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  wfc_pkg::face_t       q_face,
    input  logic [30:0]          face_length,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   peclet,
    output logic signed [16:0]   gamma_weight,
    output logic [16:0]          beta_weight,
    output logic [1:0]           status
);
    localparam int PD = 32;           // Peclet quotient bits
    localparam int WD = 17;           // weight quotient bits
    localparam int DW = 31 + FRAC_BITS;   // Peclet divisor width
    localparam int S1 = 3;            // after products
    localparam int S2 = S1 + PD;      // after Peclet divide
    localparam int S3 = S2 + 1;       // after clamp
    localparam int S4 = S3 + 1;       // after square
    localparam int SW = S4 + 1;       // weight divide start
    localparam int NW = WD;
    localparam int WE = SW + NW;      // weight divide end
    localparam int NT = WE + 1;       // output register

    // Pipeline state per stage.
    logic [NT:0]        v_reg;
    logic [30:0]        len_reg;
    logic               adv;

    assign adv     = !(v_reg[NT] && out_stall);
    assign q_stall = !adv;

    // Stages 0 to 2: product rho*|v|*L, the length product split in two halves.
    logic [61:0]  p1_reg;
    logic [61:0]  pl_reg, ph_reg;
    logic [30:0]  mia_reg, mib_reg, mic_reg;
    logic         nga_reg, ngb_reg, ngc_reg, zma_reg, zmb_reg, zmc_reg;
    logic [93:0]  num1_reg;

    // Peclet restoring divider, one bit per stage.
    logic [94:0]   pr_reg  [S1:S2];
    logic [31:0]   pq_reg  [S1:S2];
    logic [DW-1:0] pd_reg  [S1:S2];
    logic          pn_reg  [S1:S2];
    logic          pz_reg  [S1:S2];
    logic          ps_reg  [S1:S2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NT-1:0], q_valid};
        end
    end

    // The user must write face_length only while idle; the block does not enforce it. Sampled on each advance.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg  <= face_length;
            mia_reg  <= q_face.mi;
            nga_reg  <= q_face.neg;
            zma_reg  <= q_face.zero_mi;
            p1_reg   <= 62'(q_face.rho) * 62'(q_face.vmag);
            pl_reg   <= 62'(p1_reg[30:0]) * 62'(len_reg);
            ph_reg   <= 62'(p1_reg[61:31]) * 62'(len_reg);
            mib_reg  <= mia_reg;
            ngb_reg  <= nga_reg;
            zmb_reg  <= zma_reg;
            num1_reg <= (94'(ph_reg) << 31) + 94'(pl_reg);
            mic_reg  <= mib_reg;
            ngc_reg  <= ngb_reg;
            zmc_reg  <= zmb_reg;
        end
    end

    // Peclet divide: remainder starts as numerator; denominator = mi << F.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg[S1] <= {1'b0, num1_reg};
            pq_reg[S1] <= '0;
            pd_reg[S1] <= DW'(mic_reg) << FRAC_BITS;
            pn_reg[S1] <= ngc_reg;
            pz_reg[S1] <= zmc_reg;
            ps_reg[S1] <= (zmc_reg == 1'b0) &&
                          ({1'b0, num1_reg} >= (95'(DW'(mic_reg) << FRAC_BITS) << 32));
        end
    end

    for (genvar g = S1; g < S2; g++)
    begin : g_pdiv
        localparam int K = S2 - 1 - g;
        logic [94:0] sh;
        logic        ge;
        assign sh = 95'(pd_reg[g]) << K;
        assign ge = pr_reg[g] >= sh;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pr_reg[g+1] <= ge ? (pr_reg[g] - sh) : pr_reg[g];
                pq_reg[g+1] <= pq_reg[g] | (ge ? (32'd1 << K) : 32'd0);
                pd_reg[g+1] <= pd_reg[g];
                pn_reg[g+1] <= pn_reg[g];
                pz_reg[g+1] <= pz_reg[g];
                ps_reg[g+1] <= ps_reg[g];
            end
        end
    end

    // Clamp and square.
    logic [31:0] lim, magc;
    logic        satc;
    assign lim  = pn_reg[S2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign satc = ps_reg[S2] || (pq_reg[S2] > lim);
    assign magc = satc ? lim : pq_reg[S2];

    logic [31:0] mag3_reg;
    logic [63:0] sq3_reg;
    logic        n3_reg, z3_reg, s3_reg;
    logic [31:0] mag2_reg;
    logic        n2_reg, z2_reg, s2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag2_reg <= magc;
            n2_reg   <= pn_reg[S2];
            z2_reg   <= pz_reg[S2];
            s2_reg   <= satc;
            // Square the clamped magnitude.
            sq3_reg  <= 64'(mag2_reg) * 64'(mag2_reg);
            mag3_reg <= mag2_reg;
            n3_reg   <= n2_reg;
            z3_reg   <= z2_reg;
            s3_reg   <= s2_reg;
        end
    end

    // Weight divides, gamma and beta side by side, one quotient bit per stage.
    localparam int UB = 2 * FRAC_BITS;
    localparam int RW = 84;
    logic [RW-1:0] gr_reg [SW:SW+NW];
    logic [RW-1:0] gd_reg [SW:SW+NW];
    logic [RW-1:0] br_reg [SW:SW+NW];
    logic [RW-1:0] bd_reg [SW:SW+NW];
    logic [16:0]   gq_reg [SW:SW+NW];
    logic [16:0]   bq_reg [SW:SW+NW];
    logic [31:0]   wm_reg [SW:SW+NW];
    logic          wn_reg [SW:SW+NW];
    logic          wz_reg [SW:SW+NW];
    logic          ws_reg [SW:SW+NW];

    logic [RW-1:0] sqw, unitw;
    assign sqw   = RW'(sq3_reg);
    assign unitw = RW'(1) << UB;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gr_reg[SW] <= sqw << wfc_pkg::WGT_BITS;
            gd_reg[SW] <= (unitw * RW'(10)) + (sqw << 1);
            br_reg[SW] <= ((unitw * RW'(200)) + sqw) << wfc_pkg::WGT_BITS;
            bd_reg[SW] <= (unitw * RW'(200)) + (sqw * RW'(10));
            gq_reg[SW] <= '0;
            bq_reg[SW] <= '0;
            wm_reg[SW] <= mag3_reg;
            wn_reg[SW] <= n3_reg;
            wz_reg[SW] <= z3_reg;
            ws_reg[SW] <= s3_reg;
        end
    end

    for (genvar h = SW; h < SW + NW; h++)
    begin : g_wdiv
        localparam int K = SW + NW - 1 - h;
        logic [RW-1:0] gs, bs;
        logic          gge, bge;
        assign gs  = gd_reg[h] << K;
        assign bs  = bd_reg[h] << K;
        assign gge = gr_reg[h] >= gs;
        assign bge = br_reg[h] >= bs;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                gr_reg[h+1] <= gge ? (gr_reg[h] - gs) : gr_reg[h];
                br_reg[h+1] <= bge ? (br_reg[h] - bs) : br_reg[h];
                gq_reg[h+1] <= gq_reg[h] | (gge ? (17'd1 << K) : 17'd0);
                bq_reg[h+1] <= bq_reg[h] | (bge ? (17'd1 << K) : 17'd0);
                gd_reg[h+1] <= gd_reg[h];
                bd_reg[h+1] <= bd_reg[h];
                wm_reg[h+1] <= wm_reg[h];
                wn_reg[h+1] <= wn_reg[h];
                wz_reg[h+1] <= wz_reg[h];
                ws_reg[h+1] <= ws_reg[h];
            end
        end
    end

    // Output register; the tail of the valid chain marks it.
    logic signed [31:0] pe_reg;
    logic signed [16:0] ga_reg;
    logic [16:0]        be_reg;
    logic [1:0]         st_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wz_reg[WE])
            begin
                pe_reg <= '0;
                ga_reg <= '0;
                be_reg <= '0;
                st_reg <= wfc_pkg::ST_ZERO;
            end
            else
            begin
                pe_reg <= wn_reg[WE] ? (32'd0 - wm_reg[WE]) : wm_reg[WE];
                ga_reg <= wn_reg[WE] ? (17'd0 - gq_reg[WE]) : gq_reg[WE];
                be_reg <= bq_reg[WE];
                st_reg <= ws_reg[WE] ? wfc_pkg::ST_SAT : wfc_pkg::ST_OK;
            end
        end
    end

    assign out_valid    = v_reg[NT];
    assign peclet       = pe_reg;
    assign gamma_weight = ga_reg;
    assign beta_weight  = be_reg;
    assign status       = st_reg;
endmodule

// File: src/wuds_face_coefficients_core.sv
// Top level: WUDS face coefficient core, front classifier plus pipelined back end.
`timescale 1ns / 1ps
// Pipeline: front register, 3 product stages, 32+1 Peclet divide stages, clamp, square,
//   17+1 weight divide stages and the output register.
// Throughput: one face per cycle while the output is not stalled; every stage is a register.
// Stall on the output freezes the back end and a full front register; an empty front
//   register still takes a face, and it keeps accepting while the back end moves.
// Reset: rst_n clears all valid bits and sets face_length to 1.0.
module wuds_face_coefficients_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [30:0]        face_density,
    input  logic signed [31:0] face_velocity,
    input  logic [30:0]        face_viscosity,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] peclet,
    output logic signed [16:0] gamma_weight,
    output logic [16:0]        beta_weight,
    output logic [1:0]         status
);
    logic [30:0]    face_length_reg;
    logic           q_valid, q_stall;
    wfc_pkg::face_t q_face;

    // Register write is always taken.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_length_reg <= 31'd65536;
        end
        else if (cfg_valid)
        begin
            face_length_reg <= cfg_data;
        end
    end

    wfc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .face_density(face_density), .face_velocity(face_velocity),
        .face_viscosity(face_viscosity),
        .q_valid(q_valid), .q_stall(q_stall), .q_face(q_face)
    );

    wfc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_face(q_face),
        .face_length(face_length_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .peclet(peclet), .gamma_weight(gamma_weight),
        .beta_weight(beta_weight), .status(status)
    );
endmodule

// File: src/wfc_checker.sv
// Checker: port-level properties of the WUDS face coefficient core.
`timescale 1ns / 1ps
module wfc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] peclet,
    input logic signed [16:0] gamma_weight,
    input logic [16:0]        beta_weight,
    input logic [1:0]         status
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(peclet))
        else $error("result changed while stalled");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == wfc_pkg::ST_ZERO |-> peclet == 0 && beta_weight == 0)
        else $error("zero viscosity result not cleared");
    a_beta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != wfc_pkg::ST_ZERO |-> beta_weight <= 17'd65536)
        else $error("beta above one");
    a_gsign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && peclet >= 0 |-> !gamma_weight[16])
        else $error("gamma sign differs from peclet");
endmodule

bind wuds_face_coefficients_core wfc_checker u_chk (.*);
